### src/assert_macros.svh
// Assertion macros shared by the first-fit bin packer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define FFBP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define FFBP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FFBP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ffbp_pkg.sv
// Shared types and constants of the first-fit bin packer.
package ffbp_pkg;

    localparam int CAP_W        = 16;
    localparam int VOL_W        = 16;
    localparam int BIN_IDX_W    = 10;
    localparam int BINS_USE_W   = 11;
    localparam int WASTE_W      = 26;
    localparam int NUM_BINS_DEF = 1024;

    localparam logic [CAP_W-1:0]   CAP_RESET = 16'd1000;
    localparam logic [WASTE_W-1:0] TOTAL_MAX = 26'h3FF_FFFF;

    // Strobes from the controller to the datapath
    typedef struct packed {
        logic accept;     // input transfer taken
        logic clear;      // accepted item is a clear
        logic fill_step;  // write one tree node of the fill sweep
        logic rd_root;    // read root node
        logic root_chk;   // root data back, check fit
        logic desc_step;  // one level of the descent
        logic leaf_step;  // leaf data back, subtract volume
        logic asc_step;   // one level of the max refresh
        logic upd;        // update counters
        logic mul;        // bins times capacity
        logic load_out;   // load the result register
    } cmd_t;

    // Flags from the datapath to the controller
    typedef struct packed {
        logic fill_last;
        logic root_fail;
        logic next_leaf;
        logic asc_last;
    } status_t;

endpackage

### src/ffbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ffbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/ffbp_ctrl.sv
// Sequencing state machine of the first-fit bin packer.
`include "assert_macros.svh"

module ffbp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    output logic              out_valid,
    input  logic              out_ready,
    input  ffbp_pkg::status_t status,
    output ffbp_pkg::cmd_t    cmd
);

    import ffbp_pkg::*;

    typedef enum logic [10:0] {
        S_INIT     = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_FILL     = 11'b000_0000_0100,
        S_ROOT_RD  = 11'b000_0000_1000,
        S_ROOT_CHK = 11'b000_0001_0000,
        S_DESC     = 11'b000_0010_0000,
        S_LEAF     = 11'b000_0100_0000,
        S_ASC      = 11'b000_1000_0000,
        S_UPD      = 11'b001_0000_0000,
        S_MUL      = 11'b010_0000_0000,
        S_RESULT   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.fill_step = 1'b1;
                if (status.fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    cmd.clear  = kind;
                    state_next = kind ? S_FILL : S_ROOT_RD;
                end
            end
            S_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (status.fill_last)
                begin
                    state_next = S_MUL;
                end
            end
            S_ROOT_RD:
            begin
                cmd.rd_root = 1'b1;
                state_next  = S_ROOT_CHK;
            end
            S_ROOT_CHK:
            begin
                cmd.root_chk = 1'b1;
                state_next   = status.root_fail ? S_MUL : S_DESC;
            end
            S_DESC:
            begin
                cmd.desc_step = 1'b1;
                if (status.next_leaf)
                begin
                    state_next = S_LEAF;
                end
            end
            S_LEAF:
            begin
                cmd.leaf_step = 1'b1;
                state_next    = S_ASC;
            end
            S_ASC:
            begin
                cmd.asc_step = 1'b1;
                if (status.asc_last)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                // result register frees up when its transfer completes
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // Result valid flag
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Checks
    `FFBP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "accepted an item while still busy")
    `FFBP_ASSERT_IMPL(a_out_from_result, clk, rst_n, $rose(out_valid_reg), $past(state_reg == S_RESULT), "result raised outside the result step")

endmodule

### src/ffbp_datapath.sv
// Tree memory, descent and ascent logic, counters and result register.
`include "assert_macros.svh"

module ffbp_datapath #(
    parameter int NUM_BINS = ffbp_pkg::NUM_BINS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ffbp_pkg::cmd_t                     cmd,
    output ffbp_pkg::status_t                  status,
    input  logic [ffbp_pkg::VOL_W-1:0]         volume,
    input  logic                               cfg_we,
    input  logic [ffbp_pkg::CAP_W-1:0]         cfg_wdata,
    output logic [ffbp_pkg::BIN_IDX_W-1:0]     bin_index,
    output logic                               opened_new,
    output logic                               fail,
    output logic [ffbp_pkg::BINS_USE_W-1:0]    bins_in_use,
    output logic [ffbp_pkg::WASTE_W-1:0]       wasted_space
);

    import ffbp_pkg::*;

    localparam int L     = $clog2(NUM_BINS);      // tree levels below the root
    localparam int P     = 1 << L;                // padded leaf count
    localparam int AW    = L + 1;                 // node address width
    localparam int DEPTH = 2 * P;
    localparam int CW    = $clog2(NUM_BINS + 1);  // bin count width
    localparam int PW    = CW + CAP_W;            // product width
    localparam int WW    = (PW > WASTE_W) ? PW : WASTE_W;

    // Configuration register
    logic [CAP_W-1:0] cap_reg;

    // Item and walk registers
    logic [VOL_W-1:0] vol_reg;
    logic [AW-1:0]    node_reg;
    logic [CAP_W-1:0] val_reg;
    logic [L-1:0]     bin_reg;
    logic             opened_reg;
    logic             fail_reg;

    // Fill sweep registers: level base, index within level, real node count
    logic [AW-1:0]    fill_base_reg;
    logic [AW-1:0]    fill_idx_reg;
    logic [AW-1:0]    fill_limit_reg;
    logic [CAP_W-1:0] fill_val_reg;

    // Counters and product
    logic [CW-1:0]      bins_open_reg;
    logic [WASTE_W-1:0] packed_reg;
    logic [PW-1:0]      prod_reg;

    // Result register
    logic [BIN_IDX_W-1:0]  out_bin_reg;
    logic                  out_opened_reg;
    logic                  out_fail_reg;
    logic [BINS_USE_W-1:0] out_use_reg;
    logic [WASTE_W-1:0]    out_waste_reg;

    // Memory port signals
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [CAP_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic [CAP_W-1:0] ram_rdata;

    // Combinational helpers
    logic             go_left;
    logic [AW-1:0]    desc_next;
    logic [AW-1:0]    parent;
    logic [CAP_W-1:0] asc_max;
    logic [CAP_W-1:0] leaf_new;
    logic             fill_level_end;
    logic [CW-1:0]    bin_ext;
    logic [WASTE_W:0] sum_ext;
    logic [WW-1:0]    full_ext;
    logic [WW-1:0]    pk_ext;
    logic [WW-1:0]    diff;
    logic [WASTE_W-1:0] waste;
    logic [BIN_IDX_W+L-1:0]   bin_wide;
    logic [BINS_USE_W+CW-1:0] use_wide;

    ffbp_ram #(
        .WIDTH (CAP_W),
        .DEPTH (DEPTH)
    ) u_tree (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Walk arithmetic
    assign go_left        = (ram_rdata >= vol_reg);
    assign desc_next      = {node_reg[AW-2:0], ~go_left};
    assign parent         = node_reg >> 1;
    assign asc_max        = (val_reg > ram_rdata) ? val_reg : ram_rdata;
    assign leaf_new       = ram_rdata - vol_reg;
    assign fill_level_end = (fill_idx_reg == fill_base_reg - AW'(1));
    assign bin_ext        = CW'(bin_reg);
    assign sum_ext        = {1'b0, packed_reg} + (WASTE_W + 1)'(vol_reg);

    assign status.fill_last = (fill_base_reg == AW'(1));
    assign status.root_fail = (ram_rdata < vol_reg);
    assign status.next_leaf = desc_next[AW-1];
    assign status.asc_last  = (parent == AW'(1));

    // Memory port steering
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = node_reg;
        ram_wdata = leaf_new;
        ram_raddr = node_reg;
        if (cmd.fill_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = fill_base_reg | fill_idx_reg;
            ram_wdata = (fill_idx_reg < fill_limit_reg) ? fill_val_reg : '0;
        end
        if (cmd.rd_root)
        begin
            ram_raddr = AW'(1);
        end
        if (cmd.root_chk)
        begin
            ram_raddr = {node_reg[AW-2:0], 1'b0};
        end
        if (cmd.desc_step)
        begin
            ram_raddr = status.next_leaf ? desc_next : {desc_next[AW-2:0], 1'b0};
        end
        if (cmd.leaf_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = node_reg;
            ram_wdata = leaf_new;
            ram_raddr = node_reg ^ AW'(1);
        end
        if (cmd.asc_step)
        begin
            ram_we    = 1'b1;
            ram_waddr = parent;
            ram_wdata = asc_max;
            ram_raddr = parent ^ AW'(1);
        end
    end

    // Configuration and sweep control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_RESET;
            fill_base_reg  <= AW'(P);
            fill_idx_reg   <= '0;
            fill_limit_reg <= AW'(NUM_BINS);
            fill_val_reg   <= CAP_RESET;
            bins_open_reg  <= '0;
            packed_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.clear)
            begin
                fill_base_reg  <= AW'(P);
                fill_idx_reg   <= '0;
                fill_limit_reg <= AW'(NUM_BINS);
                fill_val_reg   <= cap_reg;
                bins_open_reg  <= '0;
                packed_reg     <= '0;
            end
            // sweep one level at a time from the leaves up to the root
            if (cmd.fill_step)
            begin
                if (fill_level_end)
                begin
                    fill_base_reg  <= fill_base_reg >> 1;
                    fill_limit_reg <= (fill_limit_reg + AW'(1)) >> 1;
                    fill_idx_reg   <= '0;
                end
                else
                begin
                    fill_idx_reg <= fill_idx_reg + AW'(1);
                end
            end
            // open a bin beyond the current count, saturating volume sum
            if (cmd.upd)
            begin
                if (bin_ext >= bins_open_reg)
                begin
                    bins_open_reg <= bin_ext + CW'(1);
                end
                packed_reg <= sum_ext[WASTE_W] ? TOTAL_MAX : sum_ext[WASTE_W-1:0];
            end
        end
    end

    // Item and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            vol_reg    <= volume;
            bin_reg    <= '0;
            opened_reg <= 1'b0;
            fail_reg   <= 1'b0;
        end
        if (cmd.rd_root)
        begin
            node_reg <= AW'(1);
        end
        if (cmd.root_chk && status.root_fail)
        begin
            fail_reg <= 1'b1;
        end
        if (cmd.desc_step)
        begin
            node_reg <= desc_next;
        end
        if (cmd.leaf_step)
        begin
            val_reg <= leaf_new;
            bin_reg <= node_reg[L-1:0];
        end
        if (cmd.asc_step)
        begin
            val_reg  <= asc_max;
            node_reg <= parent;
        end
        if (cmd.upd && (bin_ext >= bins_open_reg))
        begin
            opened_reg <= 1'b1;
        end
        if (cmd.mul)
        begin
            prod_reg <= PW'(bins_open_reg) * PW'(cap_reg);
        end
    end

    // Wasted space: saturate at zero and at the field maximum
    always_comb
    begin
        full_ext = WW'(prod_reg);
        pk_ext   = WW'(packed_reg);
        diff     = full_ext - pk_ext;
        if (pk_ext >= full_ext)
        begin
            waste = '0;
        end
        else if (diff > WW'(TOTAL_MAX))
        begin
            waste = TOTAL_MAX;
        end
        else
        begin
            waste = diff[WASTE_W-1:0];
        end
    end

    assign bin_wide = {{BIN_IDX_W{1'b0}}, bin_reg};
    assign use_wide = {{BINS_USE_W{1'b0}}, bins_open_reg};

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_bin_reg    <= bin_wide[BIN_IDX_W-1:0];
            out_opened_reg <= opened_reg;
            out_fail_reg   <= fail_reg;
            out_use_reg    <= use_wide[BINS_USE_W-1:0];
            out_waste_reg  <= waste;
        end
    end

    assign bin_index    = out_bin_reg;
    assign opened_new   = out_opened_reg;
    assign fail         = out_fail_reg;
    assign bins_in_use  = out_use_reg;
    assign wasted_space = out_waste_reg;

    // Checks
    `FFBP_ASSERT_IMPL(a_leaf_fits, clk, rst_n, cmd.leaf_step, ram_rdata >= vol_reg, "descent reached a leaf that cannot hold the item")
    `FFBP_ASSERT_IMPL(a_fill_addr, clk, rst_n, cmd.fill_step, fill_base_reg != '0, "fill sweep ran past the root")
    `FFBP_ASSERT_NEXT(a_total_grows, clk, rst_n, !cmd.clear, packed_reg >= $past(packed_reg), "packed total dropped without a clear")

endmodule

### src/first_fit_bin_packer.sv
// Top level of the first-fit bin packer: controller plus datapath.
//
//  channel   direction  handshake              payload
//  input     in         in_valid / in_ready    kind, volume
//  result    out        out_valid / out_ready  bin_index, opened_new, fail,
//                                              bins_in_use, wasted_space
//  config    in         cfg_we                 cfg_wdata (bin capacity)
//
// A pack item walks the tree from transfer to result: one tree memory read per
// level going down, one per level going up.
// A clear item, and the fill pass after reset, sweep all 2*P-1 tree nodes one a
// cycle, P being NUM_BINS rounded up to a power of two.
// No input is taken during the reset fill; configuration writes are.
// The result register lets the next item start while a result waits to transfer.
module first_fit_bin_packer #(
    parameter int NUM_BINS = ffbp_pkg::NUM_BINS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             kind,
    input  logic [ffbp_pkg::VOL_W-1:0]       volume,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ffbp_pkg::BIN_IDX_W-1:0]   bin_index,
    output logic                             opened_new,
    output logic                             fail,
    output logic [ffbp_pkg::BINS_USE_W-1:0]  bins_in_use,
    output logic [ffbp_pkg::WASTE_W-1:0]     wasted_space,
    input  logic                             cfg_we,
    input  logic [ffbp_pkg::CAP_W-1:0]       cfg_wdata
);

    import ffbp_pkg::*;

    cmd_t    cmd;
    status_t status;

    ffbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ffbp_datapath #(
        .NUM_BINS (NUM_BINS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .volume       (volume),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .bin_index    (bin_index),
        .opened_new   (opened_new),
        .fail         (fail),
        .bins_in_use  (bins_in_use),
        .wasted_space (wasted_space)
    );

endmodule

### dv/first_fit_bin_packer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the first-fit bin packer: directed and random packing runs.
module first_fit_bin_packer_test;
    import ffbp_pkg::*;

    localparam int   BINS         = NUM_BINS_DEF;
    localparam int   CYCLE_LIMIT  = 1_500_000;
    localparam int   DRAIN_CYCLES = 40;
    localparam int   ITEM_TARGET  = 1800;
    localparam int   CALM_ITEMS   = 150;
    localparam int   FILL_ITEMS   = 1060;
    localparam int   FILL_PHASE   = 2;
    localparam int   MAX_PRINTS   = 40;
    localparam logic KIND_PACK    = 1'b0;
    localparam logic KIND_CLEAR   = 1'b1;

    // One result transfer as the block reports it
    typedef struct packed {
        logic [BIN_IDX_W-1:0]  bin;
        logic                  opened;
        logic                  no_fit;
        logic [BINS_USE_W-1:0] in_use;
        logic [WASTE_W-1:0]    waste;
    } placement_t;

    // Tracks bin occupancy, predicts each placement and checks the results in order
    class placement_board;
        logic [CAP_W-1:0] room[BINS];
        logic [CAP_W-1:0] capacity;
        int unsigned      opened_bins;
        int unsigned      packed_sum;
        placement_t       placements_due[$];
        int               errors;
        int               packs;
        int               clears;
        int               no_fits;
        int               results;
        int               peak_bins;

        function new();
            capacity  = CAP_RESET;
            errors    = 0;
            packs     = 0;
            clears    = 0;
            no_fits   = 0;
            results   = 0;
            peak_bins = 0;
            refill();
        endfunction

        function void refill();
            foreach (room[b])
                room[b] = capacity;
            opened_bins = 0;
            packed_sum  = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] c);
            capacity = c;
        endfunction

        // bins open times capacity minus volume packed, clamped at both ends
        function int unsigned waste_now();
            int unsigned full;
            full = opened_bins * capacity;
            if (packed_sum >= full)
                return 0;
            if (full - packed_sum > TOTAL_MAX)
                return TOTAL_MAX;
            return full - packed_sum;
        endfunction

        function void place_item(logic item_kind, logic [VOL_W-1:0] vol);
            placement_t  p;
            int unsigned b;
            p = '0;
            if (item_kind == KIND_CLEAR)
            begin
                refill();
                clears++;
            end
            else
            begin
                packs++;
                // first fit: lowest bin with enough room left
                b = 0;
                while (b < BINS && room[b] < vol)
                    b++;
                if (b == BINS)
                begin
                    p.no_fit = 1'b1;
                    no_fits++;
                end
                else
                begin
                    room[b] = room[b] - vol;
                    if (b >= opened_bins)
                    begin
                        opened_bins = b + 1;
                        p.opened    = 1'b1;
                    end
                    if (vol > TOTAL_MAX - packed_sum)
                        packed_sum = TOTAL_MAX;
                    else
                        packed_sum = packed_sum + vol;
                    p.bin = b[BIN_IDX_W-1:0];
                end
                p.in_use = opened_bins[BINS_USE_W-1:0];
                p.waste  = WASTE_W'(waste_now());
                if (opened_bins > peak_bins)
                    peak_bins = opened_bins;
            end
            placements_due.push_back(p);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("%0t ns: mismatch: %s", $time, what);
        endtask

        task check_placement(placement_t got);
            placement_t want;
            results++;
            if (placements_due.size() == 0)
            begin
                report_mismatch("result transfer with no item outstanding");
                return;
            end
            want = placements_due.pop_front();
            if (got.bin !== want.bin)
                report_mismatch($sformatf("bin_index %0d, expected %0d",
                                          got.bin, want.bin));
            if (got.opened !== want.opened)
                report_mismatch($sformatf("opened_new %0b, expected %0b",
                                          got.opened, want.opened));
            if (got.no_fit !== want.no_fit)
                report_mismatch($sformatf("fail %0b, expected %0b",
                                          got.no_fit, want.no_fit));
            if (got.in_use !== want.in_use)
                report_mismatch($sformatf("bins_in_use %0d, expected %0d",
                                          got.in_use, want.in_use));
            if (got.waste !== want.waste)
                report_mismatch($sformatf("wasted_space %0d, expected %0d",
                                          got.waste, want.waste));
        endtask

        function int pending();
            return placements_due.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid;
    logic                  in_ready;
    logic                  kind;
    logic [VOL_W-1:0]      volume;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [BIN_IDX_W-1:0]  bin_index;
    logic                  opened_new;
    logic                  fail;
    logic [BINS_USE_W-1:0] bins_in_use;
    logic [WASTE_W-1:0]    wasted_space;
    logic                  cfg_we;
    logic [CAP_W-1:0]      cfg_wdata;

    placement_board board;
    int unsigned    cycle_count = 0;
    bit             gaps_on = 1'b1;
    bit             stalls_on = 1'b1;
    int             items_sent = 0;
    int             cap_writes = 0;

    first_fit_bin_packer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .volume      (volume),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bin_index   (bin_index),
        .opened_new  (opened_new),
        .fail        (fail),
        .bins_in_use (bins_in_use),
        .wasted_space(wasted_space),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Run stopped after %0d cycles with %0d results still due",
                 cycle_count, board.pending());
        $display("Regression FAIL");
        $finish;
    end

    // Result side backpressure in random bursts
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Watch both channels; every transfer is sampled at the edge that takes it
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_placement({bin_index, opened_new, fail, bins_in_use,
                                       wasted_space});
            if (in_valid && in_ready)
                board.place_item(kind, volume);
        end
    end

    // Present one item and hold it until the transfer
    task automatic push_item(logic item_kind, logic [VOL_W-1:0] vol);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= item_kind;
        volume   <= vol;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        // step the clock first so the last input transfer is already on the board
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] c);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_capacity(c);
        cap_writes++;
        @(posedge clk);
    endtask

    // Mix of extremes, tiny, medium and arbitrary capacities
    function automatic logic [CAP_W-1:0] pick_capacity();
        int unsigned roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return CAP_W'(1);
        if (roll < 4)
            return '1;
        if (roll < 7)
            return CAP_W'($urandom_range(2, 60));
        if (roll < 12)
            return CAP_W'($urandom_range(100, 5000));
        return CAP_W'($urandom);
    endfunction

    // Volumes mostly within capacity, with zeros, misfits and arbitrary values
    function automatic logic [VOL_W-1:0] pick_volume(logic [CAP_W-1:0] cap);
        int unsigned roll;
        int unsigned c;
        roll = $urandom_range(0, 99);
        c    = cap;
        if (roll < 4)
            return '0;
        if (roll < 10)
            return (c == 65535) ? VOL_W'($urandom) : VOL_W'($urandom_range(c + 1, 65535));
        if (roll < 22)
            return VOL_W'($urandom);
        if (roll < 45)
            return VOL_W'($urandom_range(0, c / 4));
        return (c == 0) ? '0 : VOL_W'($urandom_range(1, c));
    endfunction

    // One stretch of packing at the current capacity
    task automatic run_phase(int count, bit fill_mode, bit noise);
        int          n;
        int unsigned c;
        c = board.capacity;
        for (n = 0; n < count; n++)
        begin
            if (noise && $urandom_range(0, 49) == 0)
                push_item(KIND_CLEAR, VOL_W'($urandom));
            else if (fill_mode)
                push_item(KIND_PACK, VOL_W'($urandom_range(c / 2 + 1, c)));
            else
                push_item(KIND_PACK, pick_volume(board.capacity));
        end
    endtask

    initial
    begin
        int phase;
        int left;
        int count;
        in_valid  = 1'b0;
        kind      = KIND_PACK;
        volume    = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        board     = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset capacity; the first transfer also waits out the reset fill
        push_item(KIND_PACK, 16'd0);       // zero volume opens bin 0
        push_item(KIND_PACK, 16'd1000);    // exact fit in bin 0
        push_item(KIND_PACK, 16'd1001);    // larger than any bin
        push_item(KIND_PACK, 16'hFFFF);    // widest volume, no fit
        push_item(KIND_PACK, 16'd600);     // opens bin 1
        push_item(KIND_PACK, 16'd400);     // fills bin 1
        push_item(KIND_PACK, 16'd0);       // zero volume, bin 0 already open
        push_item(KIND_PACK, 16'd1);       // opens bin 2

        // Capacity raised without a clear: bins keep 1000, waste uses the new value
        drain();
        write_capacity(16'hFFFF);
        push_item(KIND_PACK, 16'd500);
        push_item(KIND_CLEAR, 16'hFFFF);   // volume is ignored on clear
        push_item(KIND_PACK, 16'hFFFF);
        push_item(KIND_PACK, 16'hFFFF);
        push_item(KIND_PACK, 16'd1);
        push_item(KIND_PACK, 16'hFFFF);

        // Capacity dropped to 1: packed volume exceeds bins times capacity
        drain();
        write_capacity(16'd1);
        push_item(KIND_PACK, 16'h5555);
        push_item(KIND_PACK, 16'hAAAA);

        // Zero capacity: only zero volumes fit
        drain();
        write_capacity(16'd0);
        push_item(KIND_CLEAR, 16'd0);
        push_item(KIND_PACK, 16'd1);
        push_item(KIND_PACK, 16'd0);
        push_item(KIND_PACK, 16'd0);

        drain();
        write_capacity(CAP_RESET);
        push_item(KIND_CLEAR, 16'd0);

        // Random phases; one of them packs until every bin is open
        phase = 0;
        while (items_sent < ITEM_TARGET - CALM_ITEMS)
        begin
            drain();
            if (phase == FILL_PHASE)
            begin
                write_capacity(CAP_W'($urandom_range(1000, 65535)));
                push_item(KIND_CLEAR, VOL_W'($urandom));
                run_phase(FILL_ITEMS, 1'b1, 1'b0);
            end
            else
            begin
                write_capacity(pick_capacity());
                if ($urandom_range(0, 7) != 0)
                    push_item(KIND_CLEAR, VOL_W'($urandom));
                left  = ITEM_TARGET - CALM_ITEMS - items_sent;
                count = $urandom_range(40, 120);
                if (count > left)
                    count = left;
                run_phase(count, 1'b0, 1'b1);
            end
            phase++;
        end

        // Last part at full rate on both sides
        drain();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        write_capacity(CAP_W'($urandom_range(100, 5000)));
        push_item(KIND_CLEAR, VOL_W'($urandom));
        run_phase(CALM_ITEMS, 1'b0, 1'b1);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d packs and %0d clears over %0d capacity settings;",
                 board.packs, board.clears, cap_writes);
        $display("%0d packs found no bin, %0d results checked, peak %0d of %0d bins open.",
                 board.no_fits, board.results, board.peak_bins, BINS);
        if (board.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
